>>> src/opl_pkg.sv
// ----------------------------------------------------------------------------
// Output list parser package
// Shared transaction types, parse state, status codes and limits.
// ----------------------------------------------------------------------------
package opl_pkg;

    localparam int MAX_OUTPUTS = 16;

    localparam logic [7:0]  MAX_SCRIPT_LEN = 8'd255;
    localparam logic [15:0] MAX_OFFSET     = 16'hffff;

    // CompactSize prefixes
    localparam logic [7:0] VI_PREFIX16 = 8'hfd;
    localparam logic [7:0] VI_PREFIX32 = 8'hfe;

    localparam logic [3:0] VI_LEN16 = 4'd2;
    localparam logic [3:0] VI_LEN32 = 4'd4;
    localparam logic [3:0] VI_LEN64 = 4'd8;
    localparam logic [3:0] VALUE_BYTES = 4'd8;

    // Status codes
    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_TRUNCATED     = 3'd1;
    localparam logic [2:0] ST_BAD_COUNT     = 3'd2;
    localparam logic [2:0] ST_BAD_SCRIPT    = 3'd3;
    localparam logic [2:0] ST_OVERFLOW      = 3'd4;
    localparam logic [2:0] ST_TOO_LONG      = 3'd5;

    // PH_COUNT must encode as zero: the parse state clears to all zeros
    typedef enum logic [2:0] {
        PH_COUNT  = 3'd0,
        PH_VALUE  = 3'd1,
        PH_SLEN   = 3'd2,
        PH_SCRIPT = 3'd3,
        PH_HALT   = 3'd4
    } opl_phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } opl_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  output_count;
        logic [15:0] first_script_offset;
        logic [7:0]  first_script_length;
        logic [15:0] rest_offset;
        logic [15:0] rest_length;
        logic [63:0] rest_value_sum;
        logic        query_found;
        logic [63:0] query_value;
        logic [15:0] query_script_offset;
        logic [7:0]  query_script_length;
    } opl_out_t;

    typedef struct packed {
        opl_phase_t  phase;
        logic [3:0]  field_byte_count;
        logic [3:0]  varint_bytes_needed;
        logic [63:0] field_accumulator;
        logic [63:0] pending_value;
        logic [7:0]  declared_outputs;
        logic [7:0]  current_output;
        logic [7:0]  script_bytes_left;
        logic [63:0] value_sum;
        logic [15:0] stream_offset;
        logic [15:0] first_offset;
        logic [7:0]  first_length;
        logic [15:0] rest_start;
        logic [15:0] rest_end;
        logic [2:0]  error_code;
        logic [63:0] query_value;
        logic [15:0] query_offset;
        logic [7:0]  query_length;
        logic        query_ok;
        logic        parse_done;
    } opl_state_t;

endpackage

>>> src/opl_parse_core.sv
// ----------------------------------------------------------------------------
// Output list parse core
// Per-byte state update of the list parser and result formatting on the
// final byte of a list.
// ----------------------------------------------------------------------------
module opl_parse_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  opl_pkg::opl_in_t  item,
    input  logic              cfg_wr_en,
    input  logic [7:0]        cfg_wr_data,
    output logic              res_valid,
    output opl_pkg::opl_out_t res_data
);

    opl_pkg::opl_state_t st_reg;
    opl_pkg::opl_state_t st_post;
    opl_pkg::opl_state_t st_next;
    logic [7:0]          query_index_reg;

    logic [7:0]  b;
    logic [63:0] acc_or;
    logic [3:0]  fbc_inc;
    logic [15:0] next_off;
    logic [64:0] sum_ext;
    logic [7:0]  left_dec;
    logic [7:0]  cur_inc;

    logic        vi_done;
    logic [63:0] vi_val;
    logic [3:0]  vi_need_next;
    logic [3:0]  vi_fbc_next;
    logic [63:0] vi_acc_next;

    logic [2:0]  status;
    logic        ok;
    logic        found;

    assign b        = item.data_byte;
    assign acc_or   = st_reg.field_accumulator
                    | ({56'd0, b} << {st_reg.field_byte_count[2:0], 3'b000});
    assign fbc_inc  = st_reg.field_byte_count + 4'd1;
    assign next_off = st_reg.stream_offset + 16'd1;
    assign sum_ext  = {1'b0, st_reg.value_sum} + {1'b0, st_reg.pending_value};
    assign left_dec = st_reg.script_bytes_left - 8'd1;
    assign cur_inc  = st_reg.current_output + 8'd1;

    // CompactSize field step
    always_comb
    begin
        vi_done      = 1'b0;
        vi_val       = 64'd0;
        vi_need_next = st_reg.varint_bytes_needed;
        vi_fbc_next  = st_reg.field_byte_count;
        vi_acc_next  = st_reg.field_accumulator;
        if (st_reg.varint_bytes_needed == 4'd0)
        begin
            if (b < opl_pkg::VI_PREFIX16)
            begin
                vi_done = 1'b1;
                vi_val  = {56'd0, b};
            end
            else
            begin
                vi_need_next = (b == opl_pkg::VI_PREFIX16) ? opl_pkg::VI_LEN16 :
                               (b == opl_pkg::VI_PREFIX32) ? opl_pkg::VI_LEN32 :
                                                             opl_pkg::VI_LEN64;
                vi_fbc_next  = 4'd0;
                vi_acc_next  = 64'd0;
            end
        end
        else
        begin
            vi_acc_next = acc_or;
            vi_fbc_next = fbc_inc;
            if (fbc_inc >= st_reg.varint_bytes_needed)
            begin
                vi_done      = 1'b1;
                vi_val       = acc_or;
                vi_need_next = 4'd0;
                vi_fbc_next  = 4'd0;
                vi_acc_next  = 64'd0;
            end
        end
    end

    // State after this byte, before the end-of-list clear
    always_comb
    begin
        st_post = st_reg;
        if (step && (st_reg.error_code != opl_pkg::ST_TOO_LONG))
        begin
            if (st_reg.stream_offset == opl_pkg::MAX_OFFSET)
            begin
                st_post.error_code = opl_pkg::ST_TOO_LONG;
                st_post.phase      = opl_pkg::PH_HALT;
            end
            else
            begin
                st_post.stream_offset = next_off;
                unique case (st_reg.phase)
                    opl_pkg::PH_COUNT:
                    begin
                        st_post.varint_bytes_needed = vi_need_next;
                        st_post.field_byte_count    = vi_fbc_next;
                        st_post.field_accumulator   = vi_acc_next;
                        if (vi_done)
                        begin
                            if ((vi_val == 64'd0) || (vi_val > 64'(opl_pkg::MAX_OUTPUTS)))
                            begin
                                if (st_reg.error_code == opl_pkg::ST_OK)
                                    st_post.error_code = opl_pkg::ST_BAD_COUNT;
                                st_post.phase = opl_pkg::PH_HALT;
                            end
                            else
                            begin
                                st_post.declared_outputs  = vi_val[7:0];
                                st_post.current_output    = 8'd0;
                                st_post.phase             = opl_pkg::PH_VALUE;
                                st_post.field_byte_count  = 4'd0;
                                st_post.field_accumulator = 64'd0;
                            end
                        end
                    end
                    opl_pkg::PH_VALUE:
                    begin
                        st_post.field_accumulator = acc_or;
                        st_post.field_byte_count  = fbc_inc;
                        if (fbc_inc >= opl_pkg::VALUE_BYTES)
                        begin
                            st_post.pending_value       = acc_or;
                            st_post.field_accumulator   = 64'd0;
                            st_post.field_byte_count    = 4'd0;
                            st_post.varint_bytes_needed = 4'd0;
                            st_post.phase               = opl_pkg::PH_SLEN;
                        end
                    end
                    opl_pkg::PH_SLEN:
                    begin
                        st_post.varint_bytes_needed = vi_need_next;
                        st_post.field_byte_count    = vi_fbc_next;
                        st_post.field_accumulator   = vi_acc_next;
                        if (vi_done)
                        begin
                            if ((vi_val == 64'd0) || (vi_val > {56'd0, opl_pkg::MAX_SCRIPT_LEN}))
                            begin
                                if (st_reg.error_code == opl_pkg::ST_OK)
                                    st_post.error_code = opl_pkg::ST_BAD_SCRIPT;
                                st_post.phase = opl_pkg::PH_HALT;
                            end
                            else
                            begin
                                st_post.script_bytes_left = vi_val[7:0];
                                if (st_reg.current_output == 8'd0)
                                begin
                                    st_post.first_offset = next_off;
                                    st_post.first_length = vi_val[7:0];
                                end
                                if (st_reg.current_output == query_index_reg)
                                begin
                                    st_post.query_offset = next_off;
                                    st_post.query_length = vi_val[7:0];
                                    st_post.query_value  = st_reg.pending_value;
                                end
                                st_post.phase = opl_pkg::PH_SCRIPT;
                            end
                        end
                    end
                    opl_pkg::PH_SCRIPT:
                    begin
                        st_post.script_bytes_left = left_dec;
                        if (left_dec == 8'd0)
                        begin
                            if (st_reg.current_output == 8'd0)
                                st_post.rest_start = next_off;
                            else if (st_reg.error_code == opl_pkg::ST_OK)
                            begin
                                // carry out of the sum marks overflow; keep the old sum
                                if (sum_ext[64])
                                    st_post.error_code = opl_pkg::ST_OVERFLOW;
                                else
                                    st_post.value_sum = sum_ext[63:0];
                            end
                            if (st_reg.current_output == query_index_reg)
                                st_post.query_ok = 1'b1;
                            st_post.rest_end       = next_off;
                            st_post.current_output = cur_inc;
                            if (cur_inc >= st_reg.declared_outputs)
                            begin
                                st_post.parse_done = 1'b1;
                                st_post.phase      = opl_pkg::PH_HALT;
                            end
                            else
                            begin
                                st_post.phase             = opl_pkg::PH_VALUE;
                                st_post.field_byte_count  = 4'd0;
                                st_post.field_accumulator = 64'd0;
                            end
                        end
                    end
                    default:
                    begin
                        // halted: drop the byte
                    end
                endcase
            end
        end
    end

    assign res_valid = step && item.last_byte;

    // Result from the state after the final byte
    always_comb
    begin
        status = st_post.error_code;
        if ((status == opl_pkg::ST_OK) && !st_post.parse_done)
            status = opl_pkg::ST_TRUNCATED;
        ok    = (status == opl_pkg::ST_OK);
        found = st_post.query_ok && (status != opl_pkg::ST_TOO_LONG);

        res_data.status              = status;
        res_data.output_count        = st_post.declared_outputs;
        res_data.first_script_offset = ok ? st_post.first_offset : 16'd0;
        res_data.first_script_length = ok ? st_post.first_length : 8'd0;
        res_data.rest_offset         = ok ? st_post.rest_start : 16'd0;
        res_data.rest_length         = ok ? (st_post.rest_end - st_post.rest_start) : 16'd0;
        res_data.rest_value_sum      = ok ? st_post.value_sum : 64'd0;
        res_data.query_found         = found;
        res_data.query_value         = found ? st_post.query_value : 64'd0;
        res_data.query_script_offset = found ? st_post.query_offset : 16'd0;
        res_data.query_script_length = found ? st_post.query_length : 8'd0;
    end

    // Clear for the next list once the result is out
    assign st_next = res_valid ? '0 : st_post;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg          <= '0;
            query_index_reg <= 8'd0;
        end
        else
        begin
            st_reg <= st_next;
            if (cfg_wr_en)
                query_index_reg <= cfg_wr_data;
        end
    end

endmodule

>>> src/opl_out_reg.sv
// ----------------------------------------------------------------------------
// Output list parser result register
// Holds one result transaction until the downstream side takes it.
// ----------------------------------------------------------------------------
module opl_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  opl_pkg::opl_out_t load_data,
    input  logic              stall,
    output logic              valid,
    output opl_pkg::opl_out_t data
);

    logic              valid_reg;
    logic              valid_next;
    opl_pkg::opl_out_t data_reg;

    // load only happens when the register is empty or being drained
    assign valid_next = load || (valid_reg && stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

>>> src/payout_output_list_parser.sv
// ----------------------------------------------------------------------------
// Payout output list parser
// Parses a serialized transaction output list and reports its layout.
// ----------------------------------------------------------------------------
// The block takes one byte of the list per clock cycle, back to back, and
// gives one result transaction for each byte flagged last_byte; no other byte
// gives a result. Each byte passes through an input register, then a
// combinational parse state update, and the result of a list is registered
// in the result register when its last byte leaves the input register. Input
// is held off only when a last byte sits in the input register while the
// previous result is still stalled at the output. query_index may be written
// only between lists.
module payout_output_list_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  opl_pkg::opl_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output opl_pkg::opl_out_t out_data,
    input  logic              cfg_wr_en,
    input  logic [7:0]        cfg_wr_data
);

    logic             in_valid_reg;
    opl_pkg::opl_in_t in_item_reg;
    logic             hold;
    logic             step;
    logic             res_valid;
    opl_pkg::opl_out_t res_data;

    // a last byte must wait until the result register can take its result
    assign hold     = in_item_reg.last_byte && out_valid && out_stall;
    assign in_stall = in_valid_reg && hold;
    assign step     = in_valid_reg && !hold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            in_item_reg <= in_data;
    end

    opl_parse_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .item        (in_item_reg),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .res_valid   (res_valid),
        .res_data    (res_data)
    );

    opl_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .load_data (res_data),
        .stall     (out_stall),
        .valid     (out_valid),
        .data      (out_data)
    );

endmodule

>>> src/opl_checker.sv
// ----------------------------------------------------------------------------
// Output list parser port checker
// Port-level checks of the result transactions, bound to the top level.
// ----------------------------------------------------------------------------
module opl_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input opl_pkg::opl_in_t  in_data,
    input logic              out_valid,
    input logic              out_stall,
    input opl_pkg::opl_out_t out_data,
    input logic              cfg_wr_en,
    input logic [7:0]        cfg_wr_data
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result transaction changed or dropped");

    // layout fields are zero unless the list parsed cleanly
    a_layout_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != opl_pkg::ST_OK) |->
            (out_data.first_script_length == 8'd0) && (out_data.rest_length == 16'd0)
            && (out_data.rest_value_sum == 64'd0) && (out_data.rest_offset == 16'd0))
        else $error("layout reported with nonzero status");

    // query fields are zero when nothing was found
    a_query_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.query_found |->
            (out_data.query_value == 64'd0) && (out_data.query_script_offset == 16'd0)
            && (out_data.query_script_length == 8'd0))
        else $error("query reported without a match");

    // a found output has a script, and an overlong list finds nothing
    a_query_sane: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.query_found |->
            (out_data.query_script_length != 8'd0)
            && (out_data.status != opl_pkg::ST_TOO_LONG)
            && (out_data.output_count != 8'd0))
        else $error("inconsistent query result");

endmodule

bind payout_output_list_parser opl_checker u_opl_checker (.*);

>>> dv/opl_list_checker.sv
// ----------------------------------------------------------------------------
// Output list parser checker
// Follows every accepted byte and register write, keeps its own copy of the
// parse state, and compares every result transaction field by field with the
// oldest predicted layout report.
// ----------------------------------------------------------------------------
module opl_list_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  opl_pkg::opl_in_t  in_data,
    input  logic              out_valid,
    input  logic              out_stall,
    input  opl_pkg::opl_out_t out_data,
    input  logic              cfg_wr_en,
    input  logic [7:0]        cfg_wr_data,
    output int                fail_count,
    output int                pending_reports
);

    logic [7:0]          query_sel;
    opl_pkg::opl_phase_t phase;
    logic [3:0]          field_cnt;
    logic [3:0]          cs_need;
    logic [63:0]         field_acc;
    logic [63:0]         out_value;
    logic [7:0]          n_outputs;
    logic [7:0]          cur_out;
    logic [7:0]          script_left;
    logic [63:0]         sum_rest;
    logic [15:0]         next_pos;
    logic [15:0]         first_off;
    logic [7:0]          first_size;
    logic [15:0]         rest_start;
    logic [15:0]         rest_end;
    logic [2:0]          err;
    logic [63:0]         q_value;
    logic [15:0]         q_off;
    logic [7:0]          q_len;
    logic                q_seen;
    logic                all_parsed;

    opl_pkg::opl_out_t report_q[$];
    int                n_checked;

    task automatic clear_list();
        phase       = opl_pkg::PH_COUNT;
        field_cnt   = '0;
        cs_need     = '0;
        field_acc   = '0;
        out_value   = '0;
        n_outputs   = '0;
        cur_out     = '0;
        script_left = '0;
        sum_rest    = '0;
        next_pos    = '0;
        first_off   = '0;
        first_size  = '0;
        rest_start  = '0;
        rest_end    = '0;
        err         = opl_pkg::ST_OK;
        q_value     = '0;
        q_off       = '0;
        q_len       = '0;
        q_seen      = 1'b0;
        all_parsed  = 1'b0;
    endtask

    task automatic note_error(input logic [2:0] code);
        if (err == opl_pkg::ST_OK)
            err = code;
    endtask

    // One byte of a CompactSize field; done is set when the field is complete.
    task automatic cs_take(input logic [7:0] b, output logic done, output logic [63:0] val);
        done = 1'b0;
        val  = '0;
        if (cs_need == 4'd0)
        begin
            if (b < opl_pkg::VI_PREFIX16)
            begin
                val  = {56'd0, b};
                done = 1'b1;
            end
            else
            begin
                cs_need   = (b == opl_pkg::VI_PREFIX16) ? opl_pkg::VI_LEN16 :
                            (b == opl_pkg::VI_PREFIX32) ? opl_pkg::VI_LEN32 :
                                                          opl_pkg::VI_LEN64;
                field_cnt = '0;
                field_acc = '0;
            end
        end
        else
        begin
            field_acc = field_acc | ({56'd0, b} << (8 * field_cnt[2:0]));
            field_cnt = field_cnt + 4'd1;
            if (field_cnt >= cs_need)
            begin
                val       = field_acc;
                cs_need   = '0;
                field_cnt = '0;
                field_acc = '0;
                done      = 1'b1;
            end
        end
    endtask

    task automatic parse_list_byte(input logic [7:0] b, input logic [15:0] pos);
        logic        done;
        logic [63:0] v;
        logic [15:0] nxt;
        nxt = pos + 16'd1;
        case (phase)
            opl_pkg::PH_COUNT:
            begin
                cs_take(b, done, v);
                if (done)
                begin
                    if (v < 64'd1 || v > 64'(opl_pkg::MAX_OUTPUTS))
                    begin
                        note_error(opl_pkg::ST_BAD_COUNT);
                        phase = opl_pkg::PH_HALT;
                    end
                    else
                    begin
                        n_outputs = v[7:0];
                        cur_out   = '0;
                        phase     = opl_pkg::PH_VALUE;
                        field_cnt = '0;
                        field_acc = '0;
                    end
                end
            end
            opl_pkg::PH_VALUE:
            begin
                field_acc = field_acc | ({56'd0, b} << (8 * field_cnt[2:0]));
                field_cnt = field_cnt + 4'd1;
                if (field_cnt >= opl_pkg::VALUE_BYTES)
                begin
                    out_value = field_acc;
                    field_acc = '0;
                    field_cnt = '0;
                    cs_need   = '0;
                    phase     = opl_pkg::PH_SLEN;
                end
            end
            opl_pkg::PH_SLEN:
            begin
                cs_take(b, done, v);
                if (done)
                begin
                    if (v < 64'd1 || v > {56'd0, opl_pkg::MAX_SCRIPT_LEN})
                    begin
                        note_error(opl_pkg::ST_BAD_SCRIPT);
                        phase = opl_pkg::PH_HALT;
                    end
                    else
                    begin
                        script_left = v[7:0];
                        if (cur_out == 8'd0)
                        begin
                            first_off  = nxt;
                            first_size = v[7:0];
                        end
                        if (cur_out == query_sel)
                        begin
                            q_off   = nxt;
                            q_len   = v[7:0];
                            q_value = out_value;
                        end
                        phase = opl_pkg::PH_SCRIPT;
                    end
                end
            end
            opl_pkg::PH_SCRIPT:
            begin
                script_left = script_left - 8'd1;
                if (script_left == 8'd0)
                begin
                    if (cur_out == 8'd0)
                        rest_start = nxt;
                    else if (err == opl_pkg::ST_OK)
                    begin
                        if (out_value > ~sum_rest)
                            note_error(opl_pkg::ST_OVERFLOW);
                        else
                            sum_rest = sum_rest + out_value;
                    end
                    if (cur_out == query_sel)
                        q_seen = 1'b1;
                    rest_end = nxt;
                    cur_out  = cur_out + 8'd1;
                    if (cur_out >= n_outputs)
                    begin
                        all_parsed = 1'b1;
                        phase      = opl_pkg::PH_HALT;
                    end
                    else
                    begin
                        phase     = opl_pkg::PH_VALUE;
                        field_cnt = '0;
                        field_acc = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic take_list_byte(input opl_pkg::opl_in_t item);
        logic [15:0]       pos;
        opl_pkg::opl_out_t rpt;
        logic              ok;
        logic              found;
        pos = next_pos;
        if (err != opl_pkg::ST_TOO_LONG)
        begin
            if (pos == opl_pkg::MAX_OFFSET)
            begin
                err   = opl_pkg::ST_TOO_LONG;
                phase = opl_pkg::PH_HALT;
            end
            else
            begin
                parse_list_byte(item.data_byte, pos);
                next_pos = pos + 16'd1;
            end
        end
        if (item.last_byte)
        begin
            rpt        = '0;
            rpt.status = err;
            if (err == opl_pkg::ST_OK && !all_parsed)
                rpt.status = opl_pkg::ST_TRUNCATED;
            ok    = (rpt.status == opl_pkg::ST_OK);
            found = q_seen && (rpt.status != opl_pkg::ST_TOO_LONG);
            rpt.output_count = n_outputs;
            if (ok)
            begin
                rpt.first_script_offset = first_off;
                rpt.first_script_length = first_size;
                rpt.rest_offset         = rest_start;
                rpt.rest_length         = rest_end - rest_start;
                rpt.rest_value_sum      = sum_rest;
            end
            if (found)
            begin
                rpt.query_found         = 1'b1;
                rpt.query_value         = q_value;
                rpt.query_script_offset = q_off;
                rpt.query_script_length = q_len;
            end
            report_q.push_back(rpt);
            clear_list();
        end
    endtask

    task automatic show_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
        if (want !== got)
            $display("  %s: expected %0h, got %0h", name, want, got);
    endtask

    task automatic check_report(input opl_pkg::opl_out_t got);
        opl_pkg::opl_out_t want;
        if (report_q.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("result transaction with nothing predicted, status %0d", got.status);
        end
        else
        begin
            want = report_q.pop_front();
            if (got !== want)
            begin
                fail_count++;
                if (fail_count <= 10)
                begin
                    $display("result %0d differs:", n_checked);
                    show_field("status", 64'(want.status), 64'(got.status));
                    show_field("output_count", 64'(want.output_count),
                               64'(got.output_count));
                    show_field("first_script_offset", 64'(want.first_script_offset),
                               64'(got.first_script_offset));
                    show_field("first_script_length", 64'(want.first_script_length),
                               64'(got.first_script_length));
                    show_field("rest_offset", 64'(want.rest_offset), 64'(got.rest_offset));
                    show_field("rest_length", 64'(want.rest_length), 64'(got.rest_length));
                    show_field("rest_value_sum", want.rest_value_sum, got.rest_value_sum);
                    show_field("query_found", 64'(want.query_found), 64'(got.query_found));
                    show_field("query_value", want.query_value, got.query_value);
                    show_field("query_script_offset", 64'(want.query_script_offset),
                               64'(got.query_script_offset));
                    show_field("query_script_length", 64'(want.query_script_length),
                               64'(got.query_script_length));
                end
            end
        end
        n_checked++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_sel  = '0;
            clear_list();
            report_q.delete();
            fail_count = 0;
            n_checked  = 0;
        end
        else
        begin
            if (cfg_wr_en)
                query_sel = cfg_wr_data;
            if (in_valid && !in_stall)
                take_list_byte(in_data);
            if (out_valid && !out_stall)
                check_report(out_data);
        end
        pending_reports <= report_q.size();
    end

endmodule

>>> dv/tb_payout_output_list_parser.sv
// ----------------------------------------------------------------------------
// Payout output list parser testbench
// Feeds directed and random serialized output lists under several idle and
// stall patterns, sweeps query_index between lists, and reports the verdict
// from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_payout_output_list_parser;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH,
        IDLE_HOLD
    } idle_mode_t;

    localparam logic [7:0] CS_PREFIX64 = 8'hff;
    localparam int         HOLD_CYCLES = 400;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              in_valid    = 1'b0;
    logic              in_stall;
    opl_pkg::opl_in_t  in_data     = '0;
    logic              out_valid;
    logic              out_stall   = 1'b0;
    opl_pkg::opl_out_t out_data;
    logic              cfg_wr_en   = 1'b0;
    logic [7:0]        cfg_wr_data = '0;

    int         fail_count;
    int         pending_reports;
    idle_mode_t idle_mode = IDLE_NONE;
    logic       hold_off  = 1'b0;
    logic [7:0] list_q[$];

    payout_output_list_parser i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    opl_list_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_data        (out_data),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .fail_count      (fail_count),
        .pending_reports (pending_reports)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #1000000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic bit send_gap();
        case (idle_mode)
            IDLE_SEND: return $urandom_range(99) < 73;
            IDLE_BOTH: return $urandom_range(99) < 38;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic bit recv_gap();
        case (idle_mode)
            IDLE_RECV: return $urandom_range(99) < 73;
            IDLE_BOTH: return $urandom_range(99) < 38;
            default:   return 1'b0;
        endcase
    endfunction

    initial
    begin
        forever
        begin
            @(posedge clk);
            out_stall <= hold_off || recv_gap();
        end
    end

    // Hold the output off long enough for the block to back up into its input.
    initial
    begin
        wait (idle_mode == IDLE_HOLD);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    task automatic send_list();
        opl_pkg::opl_in_t item;
        for (int i = 0; i < list_q.size(); i++)
        begin
            item.data_byte = list_q[i];
            item.last_byte = (i == list_q.size() - 1);
            while (send_gap())
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            in_data  <= item;
            do
                @(posedge clk);
            while (in_stall);
        end
        list_q.delete();
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_reports != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_query(input logic [7:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // width 0 picks the minimal CompactSize form; 2, 4 or 8 force a prefix
    task automatic put_cs(input logic [63:0] v, input int width);
        int w;
        w = width;
        if (w == 0)
            w = (v < {56'd0, opl_pkg::VI_PREFIX16}) ? 1 : (v <= 64'hffff) ? 2 :
                (v <= 64'hffff_ffff) ? 4 : 8;
        if (w == 1)
            list_q.push_back(v[7:0]);
        else
        begin
            list_q.push_back((w == 2) ? opl_pkg::VI_PREFIX16 :
                             (w == 4) ? opl_pkg::VI_PREFIX32 : CS_PREFIX64);
            for (int i = 0; i < w; i++)
                list_q.push_back(v[8*i +: 8]);
        end
    endtask

    task automatic put_value(input logic [63:0] v);
        for (int i = 0; i < 8; i++)
            list_q.push_back(v[8*i +: 8]);
    endtask

    task automatic put_noise(input int n);
        repeat (n) list_q.push_back(8'($urandom_range(255)));
    endtask

    task automatic put_output(input logic [63:0] v, input int slen, input int width);
        put_value(v);
        put_cs(64'(slen), width);
        put_noise((slen > 255) ? 4 : slen);
    endtask

    task automatic put_sixteen();
        put_cs(64'(opl_pkg::MAX_OUTPUTS), 0);
        put_output('1, 2, 0);
        for (int k = 1; k < opl_pkg::MAX_OUTPUTS; k++)
            put_output({32'd0, $urandom}, $urandom_range(1, 3), 0);
    endtask

    function automatic int cs_form();
        int r;
        r = $urandom_range(99);
        return (r < 85) ? 0 : (r < 90) ? 2 : (r < 95) ? 4 : 8;
    endfunction

    function automatic logic [63:0] rand_value();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return 64'($urandom_range(100000));
        else if (r < 75)
            return {$urandom, $urandom};
        else if (r < 90)
            return ~64'($urandom_range(1000));
        return '0;
    endfunction

    task automatic random_list();
        int         kind;
        int         n_out;
        int         slen;
        int         cut;
        logic [7:0] dropped;
        kind = $urandom_range(99);
        if (kind < 10)
            put_noise($urandom_range(1, 20));
        else if (kind < 15)
        begin
            put_cs(($urandom_range(1) == 0) ? 64'd0 : 64'($urandom_range(17, 300)), cs_form());
            put_noise($urandom_range(0, 6));
        end
        else
        begin
            n_out = ($urandom_range(9) == 0) ? $urandom_range(5, opl_pkg::MAX_OUTPUTS) :
                    $urandom_range(1, 4);
            put_cs(64'(n_out), cs_form());
            for (int k = 0; k < n_out; k++)
            begin
                slen = ($urandom_range(19) == 0) ? $urandom_range(9, 255) : $urandom_range(1, 8);
                if (kind < 25 && k == n_out - 1)
                    slen = ($urandom_range(1) == 0) ? 0 : $urandom_range(256, 70000);
                put_output(rand_value(), slen, cs_form());
            end
            if (kind >= 25 && kind < 35)
            begin
                cut = $urandom_range(1, list_q.size() - 1);
                while (list_q.size() > cut)
                    dropped = list_q.pop_back();
            end
            else if (kind >= 35 && $urandom_range(9) < 3)
                put_noise($urandom_range(1, 3));
        end
    endtask

    task automatic run_phase(input idle_mode_t m, input logic [7:0] q);
        int n_bytes;
        set_query(q);
        idle_mode <= m;
        n_bytes = 0;
        while (n_bytes < 30)
        begin
            random_list();
            n_bytes += list_q.size();
            send_list();
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        set_query(8'd0);

        // smallest single output
        put_cs(64'd1, 0);
        put_output(64'd0, 1, 0);
        send_list();
        // longest script length is accepted; the list ends inside the script
        put_cs(64'd1, 0);
        put_value('1);
        put_cs(64'd255, 0);
        put_noise(3);
        send_list();
        // bad counts; whatever follows is ignored
        put_cs(64'd0, 0);
        put_noise(2);
        send_list();
        put_cs(64'(opl_pkg::MAX_OUTPUTS + 1), 0);
        put_noise(1);
        send_list();
        put_cs(64'h100_0000_0000, 0);
        send_list();
        put_cs(64'd0, 2);
        send_list();
        // bad script lengths
        put_cs(64'd2, 0);
        put_output(64'd1, 0, 0);
        put_noise(1);
        send_list();
        put_cs(64'd1, 0);
        put_output(64'd1, 256, 0);
        send_list();
        // truncated inside the value, the script, after the count, in a prefix
        put_cs(64'd1, 0);
        put_noise(3);
        send_list();
        put_cs(64'd1, 0);
        put_value(64'd5);
        put_cs(64'd10, 0);
        put_noise(4);
        send_list();
        put_cs(64'd2, 0);
        send_list();
        list_q.push_back(opl_pkg::VI_PREFIX16);
        send_list();
        list_q.push_back(CS_PREFIX64);
        send_list();
        // bytes after the last output
        put_cs(64'd2, 0);
        put_output(rand_value(), 4, 0);
        put_output(rand_value(), 1, 0);
        put_noise(5);
        send_list();

        set_query(8'd15);
        put_sixteen();
        send_list();

        // overflow keeps parsing, and a later structural error does not replace it
        set_query(8'd2);
        put_cs(64'd4, 0);
        put_output(64'd0, 1, 0);
        put_output('1, 1, 0);
        put_output(64'd2, 1, 0);
        put_output(64'd9, 0, 0);
        send_list();
        // sum lands exactly on the top value
        put_cs(64'd3, 0);
        put_output(64'd0, 1, 0);
        put_output(~64'd5 + 64'd1 - 64'd1, 2, 0);
        put_output(64'd5, 1, 0);
        send_list();

        run_phase(IDLE_NONE, 8'd0);
        run_phase(IDLE_SEND, 8'd1);
        run_phase(IDLE_RECV, 8'd255);
        run_phase(IDLE_BOTH, 8'($urandom_range(3)));

        // full-rate short lists against a long output hold-off
        set_query(8'd0);
        idle_mode <= IDLE_HOLD;
        repeat (5)
        begin
            put_cs(64'd1, 0);
            put_output(rand_value(), $urandom_range(1, 3), 0);
            send_list();
        end

        drain();
        repeat (6) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
